@@ hw/rtl/vpa_pkg.sv @@
// ============================================================================
// vpa_pkg
// Shared types and constants for the variable partition allocator.
// ============================================================================
`default_nettype none

package vpa_pkg;

    localparam int MEM_SIZE             = 1024;
    localparam int ADDR_W               = $clog2(MEM_SIZE);
    localparam int SIZE_W               = $clog2(MEM_SIZE + 1);
    localparam int ID_W                 = 16;
    localparam int REQ_W                = 12;
    localparam int MAX_SEGMENTS_DEFAULT = 64;
    localparam int QUEUE_DEPTH_DEFAULT  = 8;

    typedef enum logic [2:0] {
        STAT_GRANTED  = 3'd0,
        STAT_QUEUED   = 3'd1,
        STAT_REJECTED = 3'd2,
        STAT_RELEASED = 3'd3,
        STAT_NOTFOUND = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        POL_FIRST = 2'd0,
        POL_BEST  = 2'd1,
        POL_WORST = 2'd2,
        POL_ALT   = 2'd3
    } policy_t;

    typedef enum logic {
        CMD_ALLOC   = 1'b0,
        CMD_RELEASE = 1'b1
    } command_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_CLEAR,
        CELL_PLACE,
        CELL_MERGE
    } cell_op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_MERGE,
        S_SCAN,
        S_SUM,
        S_FINISH
    } state_t;

    // one segment held by a cell
    typedef struct packed {
        logic              valid;
        logic              used;
        logic [ADDR_W-1:0] start;
        logic [SIZE_W-1:0] size;
        logic [ID_W-1:0]   owner;
    } seg_t;

    // running fit candidate passed down the chain
    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] start;
        logic [SIZE_W-1:0] size;
    } cand_t;

    // broadcast to every cell
    typedef struct packed {
        cell_op_t          op;
        logic [ADDR_W-1:0] pos_start;
        logic [SIZE_W-1:0] req_size;
        logic [1:0]        policy;
        logic              full;
        logic [ID_W-1:0]   id;
        logic              split;
        logic [ADDR_W-1:0] split_start;
        logic [SIZE_W-1:0] split_size;
    } cell_cmd_t;

endpackage

`default_nettype wire

@@ hw/rtl/vpa_cell.sv @@
// ============================================================================
// vpa_cell
// One segment slot of the chain, with its stage of the fit and sum waves.
// ============================================================================
`default_nettype none

module vpa_cell #(
    parameter bit IS_HEAD = 1'b0
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  vpa_pkg::cell_cmd_t          cmd,
    input  vpa_pkg::seg_t               left_seg,
    input  vpa_pkg::seg_t               right_seg,
    input  vpa_pkg::cand_t              cand_in,
    input  logic [vpa_pkg::SIZE_W-1:0]  sum_in,
    output vpa_pkg::seg_t               seg,
    output vpa_pkg::cand_t              cand_out,
    output logic [vpa_pkg::SIZE_W-1:0]  sum_out
);
    import vpa_pkg::*;

    seg_t              seg_reg, seg_next;
    cand_t             cand_reg, cand_next;
    logic [SIZE_W-1:0] sum_reg, sum_next;
    logic              fit, take;

    always_comb
    begin
        seg_next = seg_reg;
        case (cmd.op)
            CELL_CLEAR:
            begin
                if (seg_reg.valid && seg_reg.used && seg_reg.owner == cmd.id)
                begin
                    seg_next.used  = 1'b0;
                    seg_next.owner = '0;
                end
            end
            CELL_PLACE:
            begin
                if (cmd.split && left_seg.valid && left_seg.start == cmd.pos_start)
                begin
                    seg_next.valid = 1'b1;
                    seg_next.used  = 1'b0;
                    seg_next.start = cmd.split_start;
                    seg_next.size  = cmd.split_size;
                    seg_next.owner = '0;
                end
                else if (cmd.split && left_seg.valid && left_seg.start > cmd.pos_start)
                begin
                    seg_next = left_seg;
                end
                else if (seg_reg.valid && seg_reg.start == cmd.pos_start)
                begin
                    seg_next.used  = 1'b1;
                    seg_next.size  = cmd.req_size;
                    seg_next.owner = cmd.id;
                end
            end
            CELL_MERGE:
            begin
                if (seg_reg.valid && seg_reg.start == cmd.pos_start)
                begin
                    seg_next.size = seg_reg.size + right_seg.size;
                end
                else if (seg_reg.valid && seg_reg.start > cmd.pos_start)
                begin
                    seg_next = right_seg;
                end
            end
            default:
            begin
                seg_next = seg_reg;
            end
        endcase
    end

    // fit wave: lowest address wins ties
    always_comb
    begin
        fit  = seg_reg.valid && !seg_reg.used && seg_reg.size >= cmd.req_size
               && (seg_reg.size == cmd.req_size || !cmd.full);
        take = fit && (!cand_in.found
               || (cmd.policy == POL_BEST  && seg_reg.size < cand_in.size)
               || (cmd.policy == POL_WORST && seg_reg.size > cand_in.size));
        cand_next = cand_in;
        if (take)
        begin
            cand_next.found = 1'b1;
            cand_next.start = seg_reg.start;
            cand_next.size  = seg_reg.size;
        end
        sum_next = sum_in + ((seg_reg.valid && seg_reg.used) ? seg_reg.size : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_reg.valid <= IS_HEAD;
            seg_reg.used  <= 1'b0;
            seg_reg.start <= '0;
            seg_reg.size  <= IS_HEAD ? SIZE_W'(MEM_SIZE) : '0;
            seg_reg.owner <= '0;
            cand_reg      <= '0;
            sum_reg       <= '0;
        end
        else
        begin
            seg_reg  <= seg_next;
            cand_reg <= cand_next;
            sum_reg  <= sum_next;
        end
    end

    assign seg      = seg_reg;
    assign cand_out = cand_reg;
    assign sum_out  = sum_reg;

endmodule

`default_nettype wire

@@ hw/rtl/vpa_wait_queue.sv @@
// ============================================================================
// vpa_wait_queue
// FIFO of waiting requests; head always at entry zero.
// ============================================================================
`default_nettype none

module vpa_wait_queue #(
    parameter int DEPTH = vpa_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    input  logic [vpa_pkg::ID_W-1:0]       push_id,
    input  logic [vpa_pkg::SIZE_W-1:0]     push_size,
    input  logic                           pop,
    output logic [vpa_pkg::ID_W-1:0]       head_id,
    output logic [vpa_pkg::SIZE_W-1:0]     head_size,
    output logic                           empty,
    output logic                           full
);
    import vpa_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    logic [ID_W-1:0]   id_reg   [DEPTH];
    logic [SIZE_W-1:0] size_reg [DEPTH];
    logic [CW-1:0]     count_reg, count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push)
            count_next = count_reg + CW'(1);
        else if (pop)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            if (push && count_reg == CW'(i))
            begin
                id_reg[i]   <= push_id;
                size_reg[i] <= push_size;
            end
            else if (pop && i + 1 < DEPTH)
            begin
                id_reg[i]   <= id_reg[(i + 1) % DEPTH];
                size_reg[i] <= size_reg[(i + 1) % DEPTH];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    assign head_id   = id_reg[0];
    assign head_size = size_reg[0];
    assign empty     = (count_reg == '0);
    assign full      = (count_reg == CW'(DEPTH));

endmodule

`default_nettype wire

@@ hw/rtl/variable_partition_allocator_core.sv @@
// ============================================================================
// variable_partition_allocator_core
// First, best and worst fit allocator over an address-ordered segment chain.
// ============================================================================
// Memory of MEM_SIZE units is held as a row of MAX_SEGMENTS cells, one
// segment per cell in address order. A split shifts the cells above the pick
// up by one in the same update that places the request; a merge of two
// adjacent free segments shifts them down by one, one merge per cycle. Fit
// search and the used-size sum are waves that move one cell per cycle down
// the chain. One item is in work at a time; in_ready is high only when the
// block is idle. An allocate runs one fit wave; a rejected size goes straight
// to the finish state. A release does the owner match and, if the owner is
// found, merges free pairs until none is left, runs a fit wave if a
// request is waiting and then a sum wave. A result sits in an output register
// until its transfer, and the next item may be taken in the meantime; a new
// result waits in the finish state only while the previous one is still
// stalled. Waiting requests sit in a QUEUE_DEPTH deep FIFO; only its head is
// tried after a release.
// ============================================================================
`default_nettype none

module variable_partition_allocator_core #(
    parameter int MAX_SEGMENTS = vpa_pkg::MAX_SEGMENTS_DEFAULT,
    parameter int QUEUE_DEPTH  = vpa_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        command,
    input  logic [vpa_pkg::REQ_W-1:0]   request_size,
    input  logic [1:0]                  fit_policy,
    input  logic [vpa_pkg::ID_W-1:0]    release_id,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [2:0]                  status,
    output logic [vpa_pkg::ID_W-1:0]    grant_id,
    output logic [vpa_pkg::ADDR_W-1:0]  grant_start,
    output logic                        queue_placed,
    output logic [vpa_pkg::ID_W-1:0]    placed_id,
    output logic [vpa_pkg::ADDR_W-1:0]  placed_start,
    output logic [vpa_pkg::SIZE_W-1:0]  used_total,
    output logic [vpa_pkg::SIZE_W-1:0]  free_total
);
    import vpa_pkg::*;

    localparam int CW = $clog2(MAX_SEGMENTS + 1);

    // chain wiring
    seg_t              seg_w  [MAX_SEGMENTS];
    cand_t             cand_w [MAX_SEGMENTS];
    logic [SIZE_W-1:0] sum_w  [MAX_SEGMENTS];
    cell_cmd_t         cmd;

    // control and bookkeeping
    state_t            state_reg, state_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [ID_W-1:0]   owner_reg, owner_next;
    logic [SIZE_W-1:0] used_sum_reg, used_sum_next;
    logic [SIZE_W-1:0] req_reg, req_next;
    logic [1:0]        policy_reg, policy_next;
    logic [ID_W-1:0]   rid_reg, rid_next;
    logic              qscan_reg, qscan_next;

    // result of the item in work
    status_t           res_status_reg, res_status_next;
    logic [ID_W-1:0]   res_gid_reg, res_gid_next;
    logic [ADDR_W-1:0] res_gstart_reg, res_gstart_next;
    logic              res_qp_reg, res_qp_next;
    logic [ID_W-1:0]   res_pid_reg, res_pid_next;
    logic [ADDR_W-1:0] res_pstart_reg, res_pstart_next;

    // output register
    logic              out_valid_reg, out_valid_next;
    status_t           out_status_reg;
    logic [ID_W-1:0]   out_gid_reg;
    logic [ADDR_W-1:0] out_gstart_reg;
    logic              out_qp_reg;
    logic [ID_W-1:0]   out_pid_reg;
    logic [ADDR_W-1:0] out_pstart_reg;
    logic [SIZE_W-1:0] out_used_reg;

    // queue
    logic              q_push, q_pop, q_empty, q_full;
    logic [ID_W-1:0]   q_head_id;
    logic [SIZE_W-1:0] q_head_size;

    logic              accept, seg_full, wave_done;
    logic              owner_hit, pair_any;
    logic [ADDR_W-1:0] pair_start;
    logic              size_bad;
    cand_t             pick;
    logic [ID_W-1:0]   owner_inc;

    genvar g;
    generate
        for (g = 0; g < MAX_SEGMENTS; g++)
        begin : g_cell
            seg_t              left_s, right_s;
            cand_t             cin;
            logic [SIZE_W-1:0] sin;
            if (g == 0)
            begin : g_head
                assign left_s = '0;
                assign cin    = '0;
                assign sin    = '0;
            end
            else
            begin : g_body
                assign left_s = seg_w[g-1];
                assign cin    = cand_w[g-1];
                assign sin    = sum_w[g-1];
            end
            if (g == MAX_SEGMENTS - 1)
            begin : g_tail
                assign right_s = '0;
            end
            else
            begin : g_inner
                assign right_s = seg_w[g+1];
            end
            vpa_cell #(
                .IS_HEAD (g == 0)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .cmd      (cmd),
                .left_seg (left_s),
                .right_seg(right_s),
                .cand_in  (cin),
                .sum_in   (sin),
                .seg      (seg_w[g]),
                .cand_out (cand_w[g]),
                .sum_out  (sum_w[g])
            );
        end
    endgenerate

    vpa_wait_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_id  (owner_reg),
        .push_size(req_reg),
        .pop      (q_pop),
        .head_id  (q_head_id),
        .head_size(q_head_size),
        .empty    (q_empty),
        .full     (q_full)
    );

    assign accept    = in_valid && in_ready;
    assign seg_full  = (count_reg == CW'(MAX_SEGMENTS));
    assign wave_done = (cnt_reg == CW'(MAX_SEGMENTS));
    assign pick      = cand_w[MAX_SEGMENTS-1];
    assign size_bad  = (request_size == '0) || (request_size > REQ_W'(MEM_SIZE));
    // id 0 is never handed out
    assign owner_inc = (owner_reg == '1) ? ID_W'(1) : owner_reg + ID_W'(1);

    // owner match and first free pair, one level of OR / priority each
    always_comb
    begin
        owner_hit  = 1'b0;
        pair_any   = 1'b0;
        pair_start = '0;
        for (int i = 0; i < MAX_SEGMENTS; i++)
        begin
            if (seg_w[i].valid && seg_w[i].used && seg_w[i].owner == rid_reg)
                owner_hit = 1'b1;
        end
        for (int i = MAX_SEGMENTS - 2; i >= 0; i--)
        begin
            if (seg_w[i].valid && seg_w[i+1].valid && !seg_w[i].used && !seg_w[i+1].used)
            begin
                pair_any   = 1'b1;
                pair_start = seg_w[i].start;
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (command == CMD_RELEASE)
                        state_next = S_CLEAR;
                    else if (size_bad)
                        state_next = S_FINISH;
                    else
                        state_next = S_SCAN;
                end
            end
            S_CLEAR:
                state_next = owner_hit ? S_MERGE : S_FINISH;
            S_MERGE:
            begin
                if (!pair_any)
                    state_next = q_empty ? S_SUM : S_SCAN;
            end
            S_SCAN:
            begin
                if (wave_done)
                    state_next = qscan_reg ? S_SUM : S_FINISH;
            end
            S_SUM:
            begin
                if (wave_done)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // datapath and chain commands
    always_comb
    begin
        cmd             = '0;
        cmd.op          = CELL_HOLD;
        cmd.req_size    = req_reg;
        cmd.policy      = policy_reg;
        cmd.full        = seg_full;
        cnt_next        = '0;
        count_next      = count_reg;
        owner_next      = owner_reg;
        used_sum_next   = used_sum_reg;
        req_next        = req_reg;
        policy_next     = policy_reg;
        rid_next        = rid_reg;
        qscan_next      = qscan_reg;
        res_status_next = res_status_reg;
        res_gid_next    = res_gid_reg;
        res_gstart_next = res_gstart_reg;
        res_qp_next     = res_qp_reg;
        res_pid_next    = res_pid_reg;
        res_pstart_next = res_pstart_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        q_push          = 1'b0;
        q_pop           = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    req_next        = request_size[SIZE_W-1:0];
                    policy_next     = fit_policy;
                    rid_next        = release_id;
                    qscan_next      = 1'b0;
                    res_status_next = STAT_REJECTED;
                    res_gid_next    = '0;
                    res_gstart_next = '0;
                    res_qp_next     = 1'b0;
                    res_pid_next    = '0;
                    res_pstart_next = '0;
                end
            end
            S_CLEAR:
            begin
                cmd.op          = CELL_CLEAR;
                cmd.id          = rid_reg;
                res_status_next = owner_hit ? STAT_RELEASED : STAT_NOTFOUND;
            end
            S_MERGE:
            begin
                if (pair_any)
                begin
                    cmd.op        = CELL_MERGE;
                    cmd.pos_start = pair_start;
                    count_next    = count_reg - CW'(1);
                end
                else
                begin
                    // queue head is tried by first fit
                    req_next    = q_head_size;
                    policy_next = POL_FIRST;
                    qscan_next  = 1'b1;
                end
            end
            S_SCAN:
            begin
                cnt_next = cnt_reg + CW'(1);
                if (wave_done)
                begin
                    cnt_next = '0;
                    if (pick.found)
                    begin
                        cmd.op          = CELL_PLACE;
                        cmd.pos_start   = pick.start;
                        cmd.id          = qscan_reg ? q_head_id : owner_reg;
                        cmd.split       = (pick.size != req_reg) && !seg_full;
                        cmd.split_start = pick.start + req_reg[ADDR_W-1:0];
                        cmd.split_size  = pick.size - req_reg;
                        if (cmd.split)
                            count_next = count_reg + CW'(1);
                        if (qscan_reg)
                        begin
                            q_pop           = 1'b1;
                            res_qp_next     = 1'b1;
                            res_pid_next    = q_head_id;
                            res_pstart_next = pick.start;
                        end
                        else
                        begin
                            res_status_next = STAT_GRANTED;
                            res_gid_next    = owner_reg;
                            res_gstart_next = pick.start;
                            owner_next      = owner_inc;
                            used_sum_next   = used_sum_reg + req_reg;
                        end
                    end
                    else if (!qscan_reg && !q_full)
                    begin
                        q_push          = 1'b1;
                        res_status_next = STAT_QUEUED;
                        res_gid_next    = owner_reg;
                        owner_next      = owner_inc;
                    end
                end
            end
            S_SUM:
            begin
                cnt_next = cnt_reg + CW'(1);
                if (wave_done)
                begin
                    cnt_next      = '0;
                    used_sum_next = sum_w[MAX_SEGMENTS-1];
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                    out_valid_next = 1'b1;
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            count_reg     <= CW'(1);
            owner_reg     <= ID_W'(1);
            used_sum_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            count_reg     <= count_next;
            owner_reg     <= owner_next;
            used_sum_reg  <= used_sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        policy_reg     <= policy_next;
        rid_reg        <= rid_next;
        qscan_reg      <= qscan_next;
        res_status_reg <= res_status_next;
        res_gid_reg    <= res_gid_next;
        res_gstart_reg <= res_gstart_next;
        res_qp_reg     <= res_qp_next;
        res_pid_reg    <= res_pid_next;
        res_pstart_reg <= res_pstart_next;
        if (state_reg == S_FINISH && (!out_valid_reg || out_ready))
        begin
            out_status_reg <= res_status_reg;
            out_gid_reg    <= res_gid_reg;
            out_gstart_reg <= res_gstart_reg;
            out_qp_reg     <= res_qp_reg;
            out_pid_reg    <= res_pid_reg;
            out_pstart_reg <= res_pstart_reg;
            out_used_reg   <= used_sum_reg;
        end
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign grant_id     = out_gid_reg;
    assign grant_start  = out_gstart_reg;
    assign queue_placed = out_qp_reg;
    assign placed_id    = out_pid_reg;
    assign placed_start = out_pstart_reg;
    assign used_total   = out_used_reg;
    assign free_total   = SIZE_W'(MEM_SIZE) - out_used_reg;

endmodule

`default_nettype wire

@@ hw/rtl/vpa_checker.sv @@
// ============================================================================
// vpa_checker
// Port-level checks on the allocator result channel.
// ============================================================================
`default_nettype none

module vpa_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [2:0]                  status,
    input  logic [vpa_pkg::ID_W-1:0]    grant_id,
    input  logic [vpa_pkg::ADDR_W-1:0]  grant_start,
    input  logic                        queue_placed,
    input  logic [vpa_pkg::SIZE_W-1:0]  used_total,
    input  logic [vpa_pkg::SIZE_W-1:0]  free_total
);
    import vpa_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(grant_id))
        else $error("result changed while stalled");

    a_totals: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (used_total + free_total) == SIZE_W'(MEM_SIZE))
        else $error("used and free totals do not cover memory");

    a_no_id: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STAT_REJECTED || status == STAT_NOTFOUND)
        |-> grant_id == '0 && grant_start == '0 && !queue_placed)
        else $error("rejected or unknown-owner result carries a grant");

    a_placed_release: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && queue_placed |-> status == STAT_RELEASED)
        else $error("queue placement outside a release");

    a_granted_id: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STAT_GRANTED || status == STAT_QUEUED) |-> grant_id != '0)
        else $error("grant without an owner id");

endmodule

bind variable_partition_allocator_core vpa_checker u_vpa_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .grant_id    (grant_id),
    .grant_start (grant_start),
    .queue_placed(queue_placed),
    .used_total  (used_total),
    .free_total  (free_total)
);

`default_nettype wire
